// ===== hw/rtl/bbpe_pkg.sv =====
// Shared types, constants and a rounding helper function of the bicubic Bezier patch evaluator.
`timescale 1ns / 1ps

package bbpe_pkg;

   localparam int COORD_W = 32;                 // signed Q16.16 coordinate
   localparam int FRAC_W  = 16;                 // fraction bits of s and t
   localparam int PARAM_W = FRAC_W + 1;         // unsigned Q1.16 parameter
   localparam int WGT_W   = FRAC_W + 1;         // Bernstein and point weights
   localparam int OPB_W   = WGT_W + 1;          // room for three times a weight
   localparam int PROD_W  = COORD_W + OPB_W;    // signed lane product
   localparam int ACC_W   = PROD_W + 4;         // sum of sixteen products
   localparam int LANES   = 4;
   localparam int NPTS    = 16;
   localparam int IDX_W   = 4;
   localparam int SUM_W   = ACC_W - FRAC_W;     // accumulator after the final shift

   localparam logic [PARAM_W-1:0] PONE = PARAM_W'(1) << FRAC_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [OPB_W-1:0]   opb_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic        [WGT_W-1:0]   wgt_type;

   typedef struct packed {
      logic mul_en;
      logic acc_clr;
      logic acc_en;
   } lane_ctrl_type;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_SQ    = 10'b00_0000_0010,
      S_SQR   = 10'b00_0000_0100,
      S_CS    = 10'b00_0000_1000,
      S_CT    = 10'b00_0001_0000,
      S_CTR   = 10'b00_0010_0000,
      S_WGT   = 10'b00_0100_0000,
      S_MAC   = 10'b00_1000_0000,
      S_DRAIN = 10'b01_0000_0000,
      S_FIN   = 10'b10_0000_0000
   } state_type;

   // Round a nonnegative Q2.32 product back to Q1.16, half up.
   function automatic wgt_type round_wgt(input prod_type p);
      prod_type sum;
      sum = p + (PROD_W'(1) << (FRAC_W - 1));
      return sum[FRAC_W+WGT_W-1:FRAC_W];
   endfunction

endpackage

// ===== hw/rtl/bbpe_mac_lanes.sv =====
// Four-lane multiply-accumulate unit shared by all phases of an evaluation.
`timescale 1ns / 1ps

module bbpe_mac_lanes
   import bbpe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  coord_type     op_a [LANES],
   input  opb_type       op_b [LANES],
   output prod_type      prod [LANES],
   output acc_type       acc  [LANES]
);

   logic signed [PROD_W:0] full_prod [LANES];
   prod_type prod_ff [LANES];
   prod_type prod_in [LANES];
   acc_type  acc_ff  [LANES];
   acc_type  acc_in  [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         full_prod[i] = op_a[i] * $signed({1'b0, op_b[i]});
         prod_in[i]   = full_prod[i][PROD_W-1:0];
         acc_in[i]    = acc_ff[i] + {{(ACC_W-PROD_W){prod_ff[i][PROD_W-1]}}, prod_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (ctrl.mul_en) begin
            prod_ff[i] <= prod_in[i];
         end
         if (reset || ctrl.acc_clr) begin
            acc_ff[i] <= '0;
         end else if (ctrl.acc_en) begin
            acc_ff[i] <= acc_in[i];
         end
      end
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

// ===== hw/rtl/bicubic_bezier_patch_eval.sv =====
// Top level of the bicubic Bezier patch evaluator: point store, sequencer and output register.
`timescale 1ns / 1ps
// A load transaction writes one control point and does not start the sequencer; the block stays ready.
// An evaluate transaction steps through the Bernstein weights, the point weights, the sixteen points,
// each read and multiply-accumulated one per cycle through the four-lane unit, a drain and the
// rounding; the result is shown in the same cycle as the block becomes ready for the next request.
// Reset clears the sequencer and the output valid flag; the control point store is not cleared.

module bicubic_bezier_patch_eval
   import bbpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // point_index[3:0], coord_x[35:4], coord_y[67:36], coord_z[99:68], coord_w[131:100],
   // param_s[148:132], param_t[165:149], zero fill [167:166]
   input  logic [167:0] req_tdata,
   // opcode[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // surf_x[31:0], surf_y[63:32], surf_z[95:64], surf_w[127:96]
   output logic [127:0] rsp_tdata
);

   localparam int PT_LO = IDX_W;
   localparam int PT_W  = LANES * COORD_W;
   localparam int S_LO  = PT_LO + PT_W;
   localparam int T_LO  = S_LO + PARAM_W;

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   logic [PARAM_W-1:0] s_x_ff, s_u_ff, t_x_ff, t_u_ff;
   logic [PARAM_W-1:0] s_sat, t_sat;
   wgt_type sq_ff [LANES];
   wgt_type bs_ff [LANES];
   wgt_type bt_ff [LANES];
   wgt_type wgt_ff [NPTS];

   logic       wlat_vld_ff, wlat_vld_in;
   logic [1:0] wlat_row_ff, wlat_row_in;
   logic       rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic       mul_vld_ff, mul_vld_in;

   logic [PT_W-1:0] pts_mem [NPTS];
   logic [PT_W-1:0] rd_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [PT_W-1:0] rsp_data_ff;

   logic req_accept, load_accept, eval_accept, out_free;

   lane_ctrl_type lane_ctrl;
   coord_type op_a [LANES];
   opb_type   op_b [LANES];
   prod_type  prod [LANES];
   acc_type   acc  [LANES];

   acc_type            acc_rnd  [LANES];
   logic signed [SUM_W-1:0] acc_sum [LANES];
   coord_type          surf_sat [LANES];

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign load_accept = req_accept && (req_tuser == OP_LOAD);
   assign eval_accept = req_accept && (req_tuser == OP_EVAL);
   assign out_free    = !rsp_valid_ff || rsp_tready;

   // Parameters above one are taken as one.
   assign s_sat = (req_tdata[S_LO +: PARAM_W] > PONE) ? PONE : req_tdata[S_LO +: PARAM_W];
   assign t_sat = (req_tdata[T_LO +: PARAM_W] > PONE) ? PONE : req_tdata[T_LO +: PARAM_W];

   function automatic coord_type widen(input wgt_type v);
      return {{(COORD_W-WGT_W){1'b0}}, v};
   endfunction

   function automatic opb_type as_opb(input logic [PARAM_W-1:0] v);
      return {1'b0, v};
   endfunction

   function automatic opb_type triple(input logic [PARAM_W-1:0] v);
      return {1'b0, v} + {v, 1'b0};
   endfunction

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      wlat_vld_in = 1'b0;
      wlat_row_in = cnt_ff[1:0];
      rd_vld_in   = 1'b0;
      mul_vld_in  = rd_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      lane_ctrl.mul_en  = 1'b0;
      lane_ctrl.acc_clr = 1'b0;
      lane_ctrl.acc_en  = mul_vld_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (eval_accept) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            lane_ctrl.mul_en  = 1'b1;
            lane_ctrl.acc_clr = 1'b1;
            state_in = S_SQR;
         end
         S_SQR: begin
            state_in = S_CS;
         end
         S_CS: begin
            lane_ctrl.mul_en = 1'b1;
            state_in = S_CT;
         end
         S_CT: begin
            lane_ctrl.mul_en = 1'b1;
            state_in = S_CTR;
         end
         S_CTR: begin
            cnt_in   = '0;
            state_in = S_WGT;
         end
         S_WGT: begin
            lane_ctrl.mul_en = 1'b1;
            wlat_vld_in = 1'b1;
            cnt_in = cnt_ff + IDX_W'(1);
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            lane_ctrl.mul_en = rd_vld_ff;
            rd_vld_in = 1'b1;
            cnt_in    = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(NPTS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            lane_ctrl.mul_en = rd_vld_ff;
            if (!rd_vld_ff && !mul_vld_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Operand selection for the shared lanes.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         op_a[i] = widen(bs_ff[i]);
         op_b[i] = {1'b0, bt_ff[cnt_ff[1:0]]};
      end
      case (state_ff) inside
         S_SQ: begin
            op_a[0] = widen(s_u_ff); op_b[0] = as_opb(s_u_ff);
            op_a[1] = widen(s_x_ff); op_b[1] = as_opb(s_x_ff);
            op_a[2] = widen(t_u_ff); op_b[2] = as_opb(t_u_ff);
            op_a[3] = widen(t_x_ff); op_b[3] = as_opb(t_x_ff);
         end
         S_CS: begin
            op_a[0] = widen(sq_ff[0]); op_b[0] = as_opb(s_u_ff);
            op_a[1] = widen(sq_ff[0]); op_b[1] = triple(s_x_ff);
            op_a[2] = widen(sq_ff[1]); op_b[2] = triple(s_u_ff);
            op_a[3] = widen(sq_ff[1]); op_b[3] = as_opb(s_x_ff);
         end
         S_CT: begin
            op_a[0] = widen(sq_ff[2]); op_b[0] = as_opb(t_u_ff);
            op_a[1] = widen(sq_ff[2]); op_b[1] = triple(t_x_ff);
            op_a[2] = widen(sq_ff[3]); op_b[2] = triple(t_u_ff);
            op_a[3] = widen(sq_ff[3]); op_b[3] = as_opb(t_x_ff);
         end
         S_MAC, S_DRAIN: begin
            for (int i = 0; i < LANES; i++) begin
               op_a[i] = rd_data_ff[i*COORD_W +: COORD_W];
               op_b[i] = {1'b0, wgt_ff[rd_idx_ff]};
            end
         end
         default: begin
         end
      endcase
   end

   bbpe_mac_lanes u_lanes (
      .clock (clock),
      .reset (reset),
      .ctrl  (lane_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod),
      .acc   (acc)
   );

   // Final rounding (half up) and saturation of the four sums.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         acc_rnd[i] = acc[i] + (ACC_W'(1) << (FRAC_W - 1));
         acc_sum[i] = acc_rnd[i][ACC_W-1:FRAC_W];
         if (acc_sum[i] > SAT_HI) begin
            surf_sat[i] = SAT_HI[COORD_W-1:0];
         end else if (acc_sum[i] < SAT_LO) begin
            surf_sat[i] = SAT_LO[COORD_W-1:0];
         end else begin
            surf_sat[i] = acc_sum[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         wlat_vld_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wlat_vld_ff  <= wlat_vld_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wlat_row_ff <= wlat_row_in;
      rd_idx_ff   <= cnt_ff;
      if (eval_accept) begin
         s_x_ff <= s_sat;
         s_u_ff <= PONE - s_sat;
         t_x_ff <= t_sat;
         t_u_ff <= PONE - t_sat;
      end
      for (int i = 0; i < LANES; i++) begin
         if (state_ff == S_SQR) begin
            sq_ff[i] <= round_wgt(prod[i]);
         end
         if (state_ff == S_CT) begin
            bs_ff[i] <= round_wgt(prod[i]);
         end
         if (state_ff == S_CTR) begin
            bt_ff[i] <= round_wgt(prod[i]);
         end
         if (wlat_vld_ff) begin
            wgt_ff[{wlat_row_ff, 2'(i)}] <= round_wgt(prod[i]);
         end
      end
      if ((state_ff == S_FIN) && out_free) begin
         for (int i = 0; i < LANES; i++) begin
            rsp_data_ff[i*COORD_W +: COORD_W] <= surf_sat[i];
         end
      end
   end

   // Control point store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (load_accept) begin
         pts_mem[req_tdata[IDX_W-1:0]] <= req_tdata[PT_LO +: PT_W];
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= pts_mem[cnt_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_eval_blocks_input: assert property (@(posedge clock) disable iff (reset)
      eval_accept |=> !req_tready)
      else $error("input accepted while an evaluation is in progress");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      load_accept |=> (state_ff == S_IDLE))
      else $error("a load transaction started the sequencer");

   a_acc_only_in_mac: assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.acc_en |-> ((state_ff == S_MAC) || (state_ff == S_DRAIN)))
      else $error("accumulator updated outside the accumulate phase");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_FIN))
      else $error("result raised without a finished evaluation");

endmodule
